// ===== hw/rtl/anrcs_pkg.sv =====
package anrcs_pkg;

   localparam int MAX_NODES  = 64;
   localparam int NODE_BITS  = 6;
   localparam int CNT_BITS   = 7;
   localparam int LEVEL_BITS = 8;
   localparam int DRAW_BITS  = 16;
   localparam int THR_BITS   = 17;
   localparam int PICK_BITS  = 32;
   localparam int STEP_BITS  = $clog2(PICK_BITS + 1);

   // Actions carried by a request.
   localparam logic [2:0] ACT_STEP       = 3'd0;
   localparam logic [2:0] ACT_WRITE_LINK = 3'd1;
   localparam logic [2:0] ACT_WRITE_LVL  = 3'd2;
   localparam logic [2:0] ACT_READ_LINK  = 3'd3;
   localparam logic [2:0] ACT_READ_LVL   = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_NODE_COUNT = 3'd0;
   localparam logic [2:0] CSR_REWIRE_THR = 3'd1;
   localparam logic [2:0] CSR_COPY_THR   = 3'd2;
   localparam logic [2:0] CSR_DROP_THR   = 3'd3;
   localparam logic [2:0] CSR_LINK_THR   = 3'd4;
   localparam logic [2:0] CSR_COPY_TOL   = 3'd5;

   // Datapath operations issued by the controller.
   localparam logic [3:0] OP_NOP       = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;
   localparam logic [3:0] OP_TAKE      = 4'd2;
   localparam logic [3:0] OP_COUNT     = 4'd3;
   localparam logic [3:0] OP_MOD_START = 4'd4;
   localparam logic [3:0] OP_MOD_KEEP  = 4'd5;
   localparam logic [3:0] OP_SELECT    = 4'd6;
   localparam logic [3:0] OP_WR_U      = 4'd7;
   localparam logic [3:0] OP_WR_LINK_U = 4'd8;
   localparam logic [3:0] OP_RD_ROW    = 4'd9;
   localparam logic [3:0] OP_RMW       = 4'd10;
   localparam logic [3:0] OP_WR_LVL    = 4'd11;
   localparam logic [3:0] OP_READ_LINK = 4'd12;
   localparam logic [3:0] OP_READ_LVL  = 4'd13;
   localparam logic [3:0] OP_RD_LVL_W  = 4'd14;
   localparam logic [3:0] OP_COPY      = 4'd15;

   // Operand selects for modulo and selection operations.
   localparam logic [1:0] K_DROP = 2'd0;
   localparam logic [1:0] K_LINK = 2'd1;
   localparam logic [1:0] K_COPY = 2'd2;

   // Row selects for read-modify-write of the link matrix.
   localparam logic [1:0] R_DN = 2'd0;
   localparam logic [1:0] R_AN = 2'd1;
   localparam logic [1:0] R_V  = 2'd2;

   localparam logic [CNT_BITS-1:0]   NODE_COUNT_RST = 7'd64;
   localparam logic [THR_BITS-1:0]   REWIRE_THR_RST = 17'd32768;
   localparam logic [THR_BITS-1:0]   COPY_THR_RST   = 17'd32768;
   localparam logic [THR_BITS-1:0]   DROP_THR_RST   = 17'd22938;
   localparam logic [THR_BITS-1:0]   LINK_THR_RST   = 17'd42598;
   localparam logic [LEVEL_BITS-1:0] COPY_TOL_RST   = 8'd255;

   typedef struct packed {
      logic [2:0]           action;
      logic [NODE_BITS-1:0] node;
      logic [NODE_BITS-1:0] other_node;
      logic [7:0]           value;
      logic [DRAW_BITS-1:0] rand_rewire;
      logic [DRAW_BITS-1:0] rand_copy;
      logic [DRAW_BITS-1:0] rand_drop_kind;
      logic [DRAW_BITS-1:0] rand_link_kind;
      logic [PICK_BITS-1:0] pick_drop;
      logic [PICK_BITS-1:0] pick_link;
      logic [PICK_BITS-1:0] pick_copy;
   } req_type;

   typedef struct packed {
      logic                  rewired;
      logic                  copied;
      logic [NODE_BITS-1:0]  dropped_node;
      logic [NODE_BITS-1:0]  added_node;
      logic [LEVEL_BITS-1:0] new_level;
      logic [7:0]            read_data;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       u_active;
      logic       self_link;
      logic       deg_zero;
      logic       rewire_go;
      logic       copy_pass;
      logic       count_done;
      logic       scan_end;
      logic       mod_busy;
   } stat_type;

endpackage

// ===== hw/rtl/anrcs_mod.sv =====
module anrcs_mod import anrcs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PICK_BITS-1:0] dividend,
   input  logic [CNT_BITS-1:0]  divisor,
   output logic                 busy,
   output logic [NODE_BITS-1:0] rem
);

   logic [PICK_BITS-1:0] quo_ff, quo_in;
   logic [NODE_BITS-1:0] rem_ff, rem_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  trial;

   // Restoring remainder, one dividend bit per cycle, most significant first.
   always_comb begin
      trial  = {rem_ff, quo_ff[PICK_BITS-1]};
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = STEP_BITS'(PICK_BITS);
      end else if (cnt_ff != '0) begin
         quo_in = {quo_ff[PICK_BITS-2:0], 1'b0};
         rem_in = (trial >= divisor) ? NODE_BITS'(trial - divisor) : trial[NODE_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy = (cnt_ff != '0);
   assign rem  = rem_ff;

endmodule

// ===== hw/rtl/anrcs_dp.sv =====
module anrcs_dp import anrcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  cmd_type       cmd,
   output stat_type      stat,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [16:0]   csr_wdata
);

   // Configuration registers.
   logic [CNT_BITS-1:0]   node_count_ff;
   logic [THR_BITS-1:0]   rewire_thr_ff, copy_thr_ff, drop_thr_ff, link_thr_ff;
   logic [LEVEL_BITS-1:0] copy_tol_ff;

   // Link matrix and level store, each with per-entry valid bits.
   logic [MAX_NODES-1:0]  link_mem [MAX_NODES];
   logic [LEVEL_BITS-1:0] lvl_mem  [MAX_NODES];
   logic [MAX_NODES-1:0]  row_vld_ff, lvl_vld_ff;
   logic [MAX_NODES-1:0]  row_q_ff;
   logic [LEVEL_BITS-1:0] lvl_q_ff;
   logic                  rowv_q_ff, lvlv_q_ff;

   logic [NODE_BITS-1:0]  row_raddr, lvl_raddr, row_waddr, lvl_waddr;
   logic                  row_we, lvl_we;
   logic [MAX_NODES-1:0]  row_wdata;
   logic [LEVEL_BITS-1:0] lvl_wdata;

   req_type               item_ff, item_in;
   logic [MAX_NODES-1:0]  row_ff, row_in, eq_ff, eq_in;
   logic [LEVEL_BITS-1:0] lvl_u_ff, lvl_u_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic [NODE_BITS-1:0]  pidx_ff, pidx_in;
   logic                  pval_ff, pval_in;
   logic [NODE_BITS-1:0]  nb_same_ff, nb_same_in, nb_oth_ff, nb_oth_in;
   logic [NODE_BITS-1:0]  nn_same_ff, nn_same_in, nn_oth_ff, nn_oth_in;
   logic [NODE_BITS-1:0]  k_drop_ff, k_drop_in, k_link_ff, k_link_in, k_copy_ff, k_copy_in;
   logic [NODE_BITS-1:0]  seen_d_ff, seen_d_in, seen_a_ff, seen_a_in;
   logic [NODE_BITS-1:0]  dn_ff, dn_in, an_ff, an_in, w_ff, w_in;
   logic                  rewired_ff, rewired_in, copied_ff, copied_in;
   logic [7:0]            rd_ff, rd_in;

   logic [CNT_BITS-1:0]   n_act;
   logic [MAX_NODES-1:0]  row_q;
   logic [LEVEL_BITS-1:0] lvl_q;
   logic [NODE_BITS-1:0]  u, v, i, dc, ac, sel_addr;
   logic [CNT_BITS-1:0]   deg;
   logic                  drop_same, link_same, same, issue, in_range, not_self;
   logic [LEVEL_BITS-1:0] diff;
   logic                  mod_start, mod_busy;
   logic [PICK_BITS-1:0]  mod_dividend;
   logic [CNT_BITS-1:0]   mod_divisor;
   logic [NODE_BITS-1:0]  mod_rem;

   assign n_act     = (node_count_ff > CNT_BITS'(MAX_NODES)) ? CNT_BITS'(MAX_NODES)
                                                             : node_count_ff;
   assign row_q     = rowv_q_ff ? row_q_ff : '0;
   assign lvl_q     = lvlv_q_ff ? lvl_q_ff : '0;
   assign u         = item_ff.node;
   assign v         = item_ff.other_node;
   assign drop_same = {1'b0, item_ff.rand_drop_kind} < drop_thr_ff;
   assign link_same = {1'b0, item_ff.rand_link_kind} < link_thr_ff;
   assign dc        = drop_same ? nb_same_ff : nb_oth_ff;
   assign ac        = link_same ? nn_same_ff : nn_oth_ff;
   assign deg       = {1'b0, nb_same_ff} + {1'b0, nb_oth_ff};
   assign issue     = idx_ff < n_act;
   assign i         = idx_ff[NODE_BITS-1:0];
   assign not_self  = (i != u);
   assign diff      = (lvl_u_ff > lvl_q) ? (lvl_u_ff - lvl_q) : (lvl_q - lvl_u_ff);

   always_comb begin
      case (cmd.sel)
         R_DN:    sel_addr = dn_ff;
         R_AN:    sel_addr = an_ff;
         default: sel_addr = v;
      endcase
   end

   always_comb begin
      case (cmd.sel)
         K_DROP: begin
            mod_dividend = item_ff.pick_drop;
            mod_divisor  = {1'b0, dc};
         end
         K_LINK: begin
            mod_dividend = item_ff.pick_link;
            mod_divisor  = {1'b0, ac};
         end
         default: begin
            mod_dividend = item_ff.pick_copy;
            mod_divisor  = deg;
         end
      endcase
   end

   assign mod_start = (cmd.op == OP_MOD_START);

   anrcs_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (mod_dividend),
      .divisor  (mod_divisor),
      .busy     (mod_busy),
      .rem      (mod_rem)
   );

   always_comb begin
      item_in    = item_ff;
      row_in     = row_ff;
      eq_in      = eq_ff;
      lvl_u_in   = lvl_u_ff;
      idx_in     = idx_ff;
      pidx_in    = pidx_ff;
      pval_in    = pval_ff;
      nb_same_in = nb_same_ff;
      nb_oth_in  = nb_oth_ff;
      nn_same_in = nn_same_ff;
      nn_oth_in  = nn_oth_ff;
      k_drop_in  = k_drop_ff;
      k_link_in  = k_link_ff;
      k_copy_in  = k_copy_ff;
      seen_d_in  = seen_d_ff;
      seen_a_in  = seen_a_ff;
      dn_in      = dn_ff;
      an_in      = an_ff;
      w_in       = w_ff;
      rewired_in = rewired_ff;
      copied_in  = copied_ff;
      rd_in      = rd_ff;
      row_raddr  = u;
      lvl_raddr  = u;
      row_we     = 1'b0;
      row_waddr  = u;
      row_wdata  = row_ff;
      lvl_we     = 1'b0;
      lvl_waddr  = u;
      lvl_wdata  = lvl_q;
      same       = (lvl_q == lvl_u_ff);
      in_range   = 1'b0;

      unique case (cmd.op)
         OP_LOAD: begin
            item_in    = req_data;
            row_raddr  = req_data.node;
            lvl_raddr  = req_data.node;
            rewired_in = 1'b0;
            copied_in  = 1'b0;
            rd_in      = '0;
         end
         OP_TAKE: begin
            row_in     = row_q;
            lvl_u_in   = lvl_q;
            idx_in     = '0;
            pval_in    = 1'b0;
            nb_same_in = '0;
            nb_oth_in  = '0;
            nn_same_in = '0;
            nn_oth_in  = '0;
         end
         OP_COUNT: begin
            // Level reads run one index ahead of the classification.
            lvl_raddr = i;
            pval_in   = issue;
            pidx_in   = i;
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (pval_ff) begin
               eq_in[pidx_ff] = same;
               if (pidx_ff != u) begin
                  if (row_ff[pidx_ff]) begin
                     if (same) nb_same_in = nb_same_ff + 1'b1;
                     else      nb_oth_in  = nb_oth_ff + 1'b1;
                  end else begin
                     if (same) nn_same_in = nn_same_ff + 1'b1;
                     else      nn_oth_in  = nn_oth_ff + 1'b1;
                  end
               end
            end
         end
         OP_MOD_START: begin
            idx_in    = '0;
            seen_d_in = '0;
            seen_a_in = '0;
         end
         OP_MOD_KEEP: begin
            case (cmd.sel)
               K_DROP:  k_drop_in = mod_rem;
               K_LINK:  k_link_in = mod_rem;
               default: k_copy_in = mod_rem;
            endcase
         end
         OP_SELECT: begin
            in_range = issue;
            if (in_range) begin
               idx_in = idx_ff + 1'b1;
               if (cmd.sel == K_COPY) begin
                  if (row_ff[i] && not_self) begin
                     if (seen_d_ff == k_copy_ff) w_in = i;
                     seen_d_in = seen_d_ff + 1'b1;
                  end
               end else begin
                  if (row_ff[i] && (eq_ff[i] == drop_same) && not_self) begin
                     if (seen_d_ff == k_drop_ff) dn_in = i;
                     seen_d_in = seen_d_ff + 1'b1;
                  end
                  if (!row_ff[i] && (eq_ff[i] == link_same) && not_self) begin
                     if (seen_a_ff == k_link_ff) an_in = i;
                     seen_a_in = seen_a_ff + 1'b1;
                  end
               end
            end
         end
         OP_WR_U: begin
            row_wdata        = row_ff;
            row_wdata[dn_ff] = 1'b0;
            row_wdata[an_ff] = 1'b1;
            row_in           = row_wdata;
            row_we           = 1'b1;
            rewired_in       = 1'b1;
         end
         OP_WR_LINK_U: begin
            row_wdata    = row_ff;
            row_wdata[v] = item_ff.value[0];
            row_we       = 1'b1;
         end
         OP_RD_ROW: begin
            row_raddr = sel_addr;
         end
         OP_RMW: begin
            row_waddr    = sel_addr;
            row_wdata    = row_q;
            row_we       = 1'b1;
            case (cmd.sel)
               R_DN:    row_wdata[u] = 1'b0;
               R_AN:    row_wdata[u] = 1'b1;
               default: row_wdata[u] = item_ff.value[0];
            endcase
         end
         OP_WR_LVL: begin
            lvl_we    = 1'b1;
            lvl_wdata = item_ff.value[LEVEL_BITS-1:0];
         end
         OP_READ_LINK: begin
            rd_in = (u != v) ? {7'd0, row_ff[v]} : 8'd0;
         end
         OP_READ_LVL: begin
            rd_in = 8'(lvl_u_ff);
         end
         OP_RD_LVL_W: begin
            lvl_raddr = w_ff;
         end
         OP_COPY: begin
            if (diff <= copy_tol_ff) begin
               lvl_we    = 1'b1;
               lvl_wdata = lvl_q;
               lvl_u_in  = lvl_q;
               copied_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      row_q_ff  <= link_mem[row_raddr];
      lvl_q_ff  <= lvl_mem[lvl_raddr];
      rowv_q_ff <= row_vld_ff[row_raddr];
      lvlv_q_ff <= lvl_vld_ff[lvl_raddr];
      if (row_we) begin
         link_mem[row_waddr] <= row_wdata;
      end
      if (lvl_we) begin
         lvl_mem[lvl_waddr] <= lvl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      row_ff     <= row_in;
      eq_ff      <= eq_in;
      lvl_u_ff   <= lvl_u_in;
      idx_ff     <= idx_in;
      pidx_ff    <= pidx_in;
      nb_same_ff <= nb_same_in;
      nb_oth_ff  <= nb_oth_in;
      nn_same_ff <= nn_same_in;
      nn_oth_ff  <= nn_oth_in;
      k_drop_ff  <= k_drop_in;
      k_link_ff  <= k_link_in;
      k_copy_ff  <= k_copy_in;
      seen_d_ff  <= seen_d_in;
      seen_a_ff  <= seen_a_in;
      dn_ff      <= dn_in;
      an_ff      <= an_in;
      w_ff       <= w_in;
      rd_ff      <= rd_in;
      if (reset) begin
         row_vld_ff    <= '0;
         lvl_vld_ff    <= '0;
         pval_ff       <= 1'b0;
         rewired_ff    <= 1'b0;
         copied_ff     <= 1'b0;
         node_count_ff <= NODE_COUNT_RST;
         rewire_thr_ff <= REWIRE_THR_RST;
         copy_thr_ff   <= COPY_THR_RST;
         drop_thr_ff   <= DROP_THR_RST;
         link_thr_ff   <= LINK_THR_RST;
         copy_tol_ff   <= COPY_TOL_RST;
      end else begin
         pval_ff    <= pval_in;
         rewired_ff <= rewired_in;
         copied_ff  <= copied_in;
         if (row_we) row_vld_ff[row_waddr] <= 1'b1;
         if (lvl_we) lvl_vld_ff[lvl_waddr] <= 1'b1;
         if (csr_we) begin
            unique case (csr_index)
               CSR_NODE_COUNT: node_count_ff <= csr_wdata[CNT_BITS-1:0];
               CSR_REWIRE_THR: rewire_thr_ff <= csr_wdata;
               CSR_COPY_THR:   copy_thr_ff   <= csr_wdata;
               CSR_DROP_THR:   drop_thr_ff   <= csr_wdata;
               CSR_LINK_THR:   link_thr_ff   <= csr_wdata;
               CSR_COPY_TOL:   copy_tol_ff   <= csr_wdata[LEVEL_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      stat.action     = item_ff.action;
      stat.u_active   = {1'b0, u} < n_act;
      stat.self_link  = (u == v);
      stat.deg_zero   = (deg == '0);
      stat.rewire_go  = ({1'b0, item_ff.rand_rewire} < rewire_thr_ff)
                        && (dc != '0) && (ac != '0);
      stat.copy_pass  = {1'b0, item_ff.rand_copy} < copy_thr_ff;
      stat.count_done = !issue && !pval_ff;
      stat.scan_end   = !issue;
      stat.mod_busy   = mod_busy;
   end

   always_comb begin
      rsp_data.rewired      = rewired_ff;
      rsp_data.copied       = copied_ff;
      rsp_data.dropped_node = rewired_ff ? dn_ff : '0;
      rsp_data.added_node   = rewired_ff ? an_ff : '0;
      rsp_data.new_level    = (item_ff.action == ACT_STEP) ? lvl_u_ff : '0;
      rsp_data.read_data    = rd_ff;
   end

endmodule

// ===== hw/rtl/anrcs_ctrl.sv =====
module anrcs_ctrl import anrcs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_valid
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_TAKE     = 5'd1;
   localparam logic [4:0] S_DISP     = 5'd2;
   localparam logic [4:0] S_COUNT    = 5'd3;
   localparam logic [4:0] S_CHECK    = 5'd4;
   localparam logic [4:0] S_MD_S     = 5'd5;
   localparam logic [4:0] S_MD_W     = 5'd6;
   localparam logic [4:0] S_ML_S     = 5'd7;
   localparam logic [4:0] S_ML_W     = 5'd8;
   localparam logic [4:0] S_SEL_RW   = 5'd9;
   localparam logic [4:0] S_WR_U     = 5'd10;
   localparam logic [4:0] S_RD_DN    = 5'd11;
   localparam logic [4:0] S_RMW_DN   = 5'd12;
   localparam logic [4:0] S_RD_AN    = 5'd13;
   localparam logic [4:0] S_RMW_AN   = 5'd14;
   localparam logic [4:0] S_COPY_CHK = 5'd15;
   localparam logic [4:0] S_MC_S     = 5'd16;
   localparam logic [4:0] S_MC_W     = 5'd17;
   localparam logic [4:0] S_SEL_C    = 5'd18;
   localparam logic [4:0] S_RD_W     = 5'd19;
   localparam logic [4:0] S_COPY     = 5'd20;
   localparam logic [4:0] S_WL_U     = 5'd21;
   localparam logic [4:0] S_RD_V     = 5'd22;
   localparam logic [4:0] S_RMW_V    = 5'd23;
   localparam logic [4:0] S_WR_LVL   = 5'd24;
   localparam logic [4:0] S_RD_LINK  = 5'd25;
   localparam logic [4:0] S_RD_LVL   = 5'd26;
   localparam logic [4:0] S_RESP     = 5'd27;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NOP;
      cmd.sel  = K_DROP;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            cmd.op   = OP_TAKE;
            state_in = S_DISP;
         end
         S_DISP: begin
            unique case (stat.action)
               ACT_STEP:       state_in = stat.u_active ? S_COUNT : S_RESP;
               ACT_WRITE_LINK: state_in = stat.self_link ? S_RESP : S_WL_U;
               ACT_WRITE_LVL:  state_in = S_WR_LVL;
               ACT_READ_LINK:  state_in = S_RD_LINK;
               ACT_READ_LVL:   state_in = S_RD_LVL;
               default:        state_in = S_RESP;
            endcase
         end
         S_COUNT: begin
            cmd.op = OP_COUNT;
            if (stat.count_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.deg_zero)       state_in = S_RESP;
            else if (stat.rewire_go) state_in = S_MD_S;
            else                     state_in = S_COPY_CHK;
         end
         S_MD_S: begin
            cmd.op   = OP_MOD_START;
            cmd.sel  = K_DROP;
            state_in = S_MD_W;
         end
         S_MD_W: begin
            cmd.op  = OP_MOD_KEEP;
            cmd.sel = K_DROP;
            if (!stat.mod_busy) state_in = S_ML_S;
         end
         S_ML_S: begin
            cmd.op   = OP_MOD_START;
            cmd.sel  = K_LINK;
            state_in = S_ML_W;
         end
         S_ML_W: begin
            cmd.op  = OP_MOD_KEEP;
            cmd.sel = K_LINK;
            if (!stat.mod_busy) state_in = S_SEL_RW;
         end
         S_SEL_RW: begin
            cmd.op  = OP_SELECT;
            cmd.sel = K_DROP;
            if (stat.scan_end) state_in = S_WR_U;
         end
         S_WR_U: begin
            cmd.op   = OP_WR_U;
            state_in = S_RD_DN;
         end
         S_RD_DN: begin
            cmd.op   = OP_RD_ROW;
            cmd.sel  = R_DN;
            state_in = S_RMW_DN;
         end
         S_RMW_DN: begin
            cmd.op   = OP_RMW;
            cmd.sel  = R_DN;
            state_in = S_RD_AN;
         end
         S_RD_AN: begin
            cmd.op   = OP_RD_ROW;
            cmd.sel  = R_AN;
            state_in = S_RMW_AN;
         end
         S_RMW_AN: begin
            cmd.op   = OP_RMW;
            cmd.sel  = R_AN;
            state_in = S_COPY_CHK;
         end
         S_COPY_CHK: begin
            state_in = stat.copy_pass ? S_MC_S : S_RESP;
         end
         S_MC_S: begin
            cmd.op   = OP_MOD_START;
            cmd.sel  = K_COPY;
            state_in = S_MC_W;
         end
         S_MC_W: begin
            cmd.op  = OP_MOD_KEEP;
            cmd.sel = K_COPY;
            if (!stat.mod_busy) state_in = S_SEL_C;
         end
         S_SEL_C: begin
            cmd.op  = OP_SELECT;
            cmd.sel = K_COPY;
            if (stat.scan_end) state_in = S_RD_W;
         end
         S_RD_W: begin
            cmd.op   = OP_RD_LVL_W;
            state_in = S_COPY;
         end
         S_COPY: begin
            cmd.op   = OP_COPY;
            state_in = S_RESP;
         end
         S_WL_U: begin
            cmd.op   = OP_WR_LINK_U;
            state_in = S_RD_V;
         end
         S_RD_V: begin
            cmd.op   = OP_RD_ROW;
            cmd.sel  = R_V;
            state_in = S_RMW_V;
         end
         S_RMW_V: begin
            cmd.op   = OP_RMW;
            cmd.sel  = R_V;
            state_in = S_RESP;
         end
         S_WR_LVL: begin
            cmd.op   = OP_WR_LVL;
            state_in = S_RESP;
         end
         S_RD_LINK: begin
            cmd.op   = OP_READ_LINK;
            state_in = S_RESP;
         end
         S_RD_LVL: begin
            cmd.op   = OP_READ_LVL;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

// ===== hw/rtl/adaptive_network_rewire_copy_step_core.sv =====
// Adaptive network engine: a 64-node symmetric link matrix and one opinion level
// per node, with software access and coevolving voter model steps.
// A request transfers at a clock edge where start is high and busy is low; busy
// then stays high until the single result has been presented.
// Each request yields exactly one result, shown on rsp_data for one cycle with
// rsp_valid high; the receiver cannot stall, so the result must be taken then.
// A self-link write, an unknown action or a step on an inactive node goes to its
// result directly. A counting-only step ends with the neighbor scan, which reads
// one level per cycle from the level store; with rewire and copy, each modulo
// by a candidate count runs bit-serially over the 32-bit pick and each candidate
// selection walks the node row one position per cycle.
// Only one request is in flight at a time; busy drops in the cycle after the
// result, so the next request transfers only once the previous one is through.
// Reset clears all links and levels at once through per-row and per-entry valid
// bits and restores the configuration defaults; no clearing pass is needed.
// Configuration is written through csr_we/csr_index/csr_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
module adaptive_network_rewire_copy_step_core import anrcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   anrcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   anrcs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
